// ===== sv/lbc_pkg.sv =====
// Shared types and codes for the LRU block buffer cache directory.
// Used by lbc_cell and lru_block_buffer_cache; depends on nothing.
`default_nettype none

package lbc_pkg;

    localparam int ENTRIES_DEF = 64;

    localparam logic [7:0] REFS_MAX = 8'hFF;

    // request commands
    localparam logic CMD_READ    = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_FREE  = 2'd1;
    localparam logic [1:0] ST_NOT_HELD = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    // operations broadcast to the cell row
    localparam logic [1:0] OP_NONE   = 2'd0;
    localparam logic [1:0] OP_HEAD   = 2'd1;
    localparam logic [1:0] OP_TAIL   = 2'd2;
    localparam logic [1:0] OP_UPDATE = 2'd3;

    typedef struct packed {
        logic        command;
        logic [31:0] block_number;
        logic [5:0]  slot;
    } t_req;

    typedef struct packed {
        logic [5:0]  slot_out;
        logic        hit;
        logic        write_back;
        logic [31:0] old_block;
        logic        fetch;
        logic [1:0]  status;
    } t_rsp;

    typedef struct packed {
        logic [31:0] tag;
        logic        valid;
        logic [7:0]  refs;
    } t_entry;

    typedef struct packed {
        logic [1:0] op;
        t_entry     ent;
    } t_cell_cmd;

endpackage

`default_nettype wire

// ===== sv/lru_block_buffer_cache.sv =====
// LRU block buffer cache directory with reference counts.
// Request channel (i_req_valid / o_req_stall / i_req): a read of a block number
// or a release of a held slot. Response channel (o_rsp_valid / i_rsp_stall /
// o_rsp): one result beat per request, in request order.
// The list is a row of cells, one per recency position. Each request has a
// lookup cycle where every cell compares its entry and the matching and victim
// cells are gathered into registers, then an update cycle where any row change
// is made (a shift by one place toward head or tail, or a count changed in
// place) and the result is registered. The next request beat can be taken in
// the update cycle of the one before.
// A stalled response holds in the output register; a new request may still be
// accepted and looked up, and its update waits until the register frees.
// Reset (synchronous, active low) clears all valid bits and counts and places
// entry i at position i; tags are not cleared, a cleared valid bit guards them.
// Depends on lbc_pkg and lbc_cell.
`default_nettype none

module lru_block_buffer_cache #(
    parameter int ENTRIES = lbc_pkg::ENTRIES_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_req_valid,
    output logic               o_req_stall,
    input  wire lbc_pkg::t_req i_req,
    output logic               o_rsp_valid,
    input  wire logic          i_rsp_stall,
    output lbc_pkg::t_rsp      o_rsp
);
    import lbc_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = ((IW > 6) ? IW : 6) + 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FIND  = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;

    logic [1:0]    r_state, n_state;
    t_req          r_req;
    t_rsp          r_rsp, n_rsp;
    logic          r_rsp_valid, n_rsp_valid;

    logic          req_fire;
    logic          out_free;
    logic          apply_go;
    logic          slot_ok;

    t_entry        cell_ent [ENTRIES];
    logic [IW-1:0] cell_idx [ENTRIES];
    logic [ENTRIES-1:0] match;
    logic [ENTRIES-1:0] vict;

    t_cell_cmd     cell_cmd;
    logic [IW-1:0] cmd_pos;
    logic [IW-1:0] cmd_idx;

    // gathered lookup results
    logic          hit_any, vic_any;
    logic [IW-1:0] hit_pos, hit_idx, vic_pos, vic_idx;
    t_entry        hit_ent, vic_ent;
    logic          r_hit_any, r_vic_any;
    logic [IW-1:0] r_hit_pos, r_hit_idx, r_vic_pos, r_vic_idx;
    t_entry        r_hit_ent, r_vic_ent;

    assign out_free    = !r_rsp_valid || !i_rsp_stall;
    assign apply_go    = (r_state == S_APPLY) && out_free;
    assign o_req_stall = (r_state == S_FIND) || ((r_state == S_APPLY) && !out_free);
    assign req_fire    = i_req_valid && !o_req_stall;
    assign slot_ok     = (CW'(r_req.slot) < CW'(ENTRIES));

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        localparam int GL = (g == 0) ? g : g - 1;
        localparam int GR = (g == ENTRIES - 1) ? g : g + 1;
        lbc_cell #(
            .IW  (IW),
            .N   (ENTRIES),
            .POS (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (cell_cmd),
            .i_cmd_pos   (cmd_pos),
            .i_cmd_idx   (cmd_idx),
            .i_left_ent  (cell_ent[GL]),
            .i_left_idx  (cell_idx[GL]),
            .i_right_ent (cell_ent[GR]),
            .i_right_idx (cell_idx[GR]),
            .i_key_cmd   (r_req.command),
            .i_key_tag   (r_req.block_number),
            .i_key_idx   (IW'(r_req.slot)),
            .i_key_ok    (slot_ok),
            .o_ent       (cell_ent[g]),
            .o_idx       (cell_idx[g]),
            .o_match     (match[g]),
            .o_vict      (vict[g])
        );
    end

    // at most one cell matches and at most one is the victim: and-or gather
    always_comb begin
        hit_any = 1'b0;
        vic_any = 1'b0;
        hit_pos = '0;
        hit_idx = '0;
        vic_pos = '0;
        vic_idx = '0;
        hit_ent = '0;
        vic_ent = '0;
        for (int p = 0; p < ENTRIES; p++) begin
            hit_any = hit_any | match[p];
            vic_any = vic_any | vict[p];
            hit_pos = hit_pos | (match[p] ? IW'(p) : '0);
            vic_pos = vic_pos | (vict[p] ? IW'(p) : '0);
            hit_idx = hit_idx | (match[p] ? cell_idx[p] : '0);
            vic_idx = vic_idx | (vict[p] ? cell_idx[p] : '0);
            hit_ent = hit_ent | (match[p] ? cell_ent[p] : '0);
            vic_ent = vic_ent | (vict[p] ? cell_ent[p] : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_req <= i_req;
        end
        if (r_state == S_FIND) begin
            r_hit_any <= hit_any;
            r_hit_pos <= hit_pos;
            r_hit_idx <= hit_idx;
            r_hit_ent <= hit_ent;
            r_vic_any <= vic_any;
            r_vic_pos <= vic_pos;
            r_vic_idx <= vic_idx;
            r_vic_ent <= vic_ent;
        end
        if (apply_go) begin
            r_rsp <= n_rsp;
        end
    end

    // decide the row update and the result beat
    always_comb begin
        cell_cmd = '0;
        cmd_pos  = '0;
        cmd_idx  = '0;
        n_rsp    = '0;
        if (r_req.command == CMD_READ) begin
            priority if (r_hit_any) begin
                n_rsp.slot_out = 6'(r_hit_idx);
                n_rsp.hit      = 1'b1;
                if (r_hit_ent.refs == REFS_MAX) begin
                    n_rsp.status = ST_FULL;
                end else begin
                    cell_cmd.op        = OP_HEAD;
                    cell_cmd.ent       = r_hit_ent;
                    cell_cmd.ent.refs  = 8'(r_hit_ent.refs + 8'd1);
                    cmd_pos            = r_hit_pos;
                    cmd_idx            = r_hit_idx;
                end
            end else if (r_vic_any) begin
                cell_cmd.op        = OP_HEAD;
                cell_cmd.ent.tag   = r_req.block_number;
                cell_cmd.ent.valid = 1'b1;
                cell_cmd.ent.refs  = 8'd1;
                cmd_pos            = r_vic_pos;
                cmd_idx            = r_vic_idx;
                n_rsp.slot_out     = 6'(r_vic_idx);
                n_rsp.write_back   = r_vic_ent.valid;
                n_rsp.old_block    = r_vic_ent.valid ? r_vic_ent.tag : '0;
                n_rsp.fetch        = 1'b1;
            end else begin
                n_rsp.status = ST_NO_FREE;
            end
        end else begin
            n_rsp.slot_out = r_req.slot;
            if (!r_hit_any || (r_hit_ent.refs == '0)) begin
                n_rsp.status = ST_NOT_HELD;
            end else begin
                cell_cmd.ent      = r_hit_ent;
                cell_cmd.ent.refs = 8'(r_hit_ent.refs - 8'd1);
                cell_cmd.op       = (r_hit_ent.refs == 8'd1) ? OP_TAIL : OP_UPDATE;
                cmd_pos           = r_hit_pos;
                cmd_idx           = r_hit_idx;
            end
        end
        if (!apply_go) begin
            cell_cmd.op = OP_NONE;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  n_state = req_fire ? S_FIND : S_IDLE;
            S_FIND:  n_state = S_APPLY;
            S_APPLY: begin
                if (apply_go) begin
                    n_state = req_fire ? S_FIND : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign n_rsp_valid = apply_go ? 1'b1 : (i_rsp_stall ? r_rsp_valid : 1'b0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // referenced entries form an unbroken run from the head
    logic order_bad;
    always_comb begin
        order_bad = 1'b0;
        for (int p = 0; p < ENTRIES - 1; p++) begin
            order_bad = order_bad | ((cell_ent[p].refs == '0) && (cell_ent[p + 1].refs != '0));
        end
    end

    a_order_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !order_bad)
        else $error("referenced entry behind an unreferenced one");

    a_single_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIND) |-> $onehot0(match))
        else $error("more than one cell matched the lookup");

    a_single_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(vict))
        else $error("more than one victim candidate");

    a_head_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (apply_go && (cell_cmd.op == OP_HEAD)) |=> (cell_idx[0] == $past(cmd_idx)))
        else $error("moved entry did not land at the head");

endmodule

`default_nettype wire

// ===== sv/lbc_cell.sv =====
// One position of the recency list: holds the entry sitting there and shifts
// toward head or tail, or updates its count, on command. Depends on lbc_pkg.
`default_nettype none

module lbc_cell #(
    parameter int IW  = 6,
    parameter int N   = 64,
    parameter int POS = 0
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire lbc_pkg::t_cell_cmd i_cmd,
    input  wire logic [IW-1:0]      i_cmd_pos,
    input  wire logic [IW-1:0]      i_cmd_idx,
    input  wire lbc_pkg::t_entry    i_left_ent,
    input  wire logic [IW-1:0]      i_left_idx,
    input  wire lbc_pkg::t_entry    i_right_ent,
    input  wire logic [IW-1:0]      i_right_idx,
    input  wire logic               i_key_cmd,
    input  wire logic [31:0]        i_key_tag,
    input  wire logic [IW-1:0]      i_key_idx,
    input  wire logic               i_key_ok,
    output lbc_pkg::t_entry         o_ent,
    output logic [IW-1:0]           o_idx,
    output logic                    o_match,
    output logic                    o_vict
);
    import lbc_pkg::*;

    localparam logic [IW-1:0] P     = IW'(POS);
    localparam bit            FIRST = (POS == 0);
    localparam bit            LAST  = (POS == N - 1);

    logic [31:0]   r_tag,   n_tag;
    logic          r_valid, n_valid;
    logic [7:0]    r_refs,  n_refs;
    logic [IW-1:0] r_idx,   n_idx;
    logic          zero_here;
    logic          zero_left;

    always_comb begin
        n_tag   = r_tag;
        n_valid = r_valid;
        n_refs  = r_refs;
        n_idx   = r_idx;
        unique case (i_cmd.op)
            OP_HEAD: begin
                if (FIRST) begin
                    n_tag   = i_cmd.ent.tag;
                    n_valid = i_cmd.ent.valid;
                    n_refs  = i_cmd.ent.refs;
                    n_idx   = i_cmd_idx;
                end else if (P <= i_cmd_pos) begin
                    n_tag   = i_left_ent.tag;
                    n_valid = i_left_ent.valid;
                    n_refs  = i_left_ent.refs;
                    n_idx   = i_left_idx;
                end
            end
            OP_TAIL: begin
                if (LAST) begin
                    n_tag   = i_cmd.ent.tag;
                    n_valid = i_cmd.ent.valid;
                    n_refs  = i_cmd.ent.refs;
                    n_idx   = i_cmd_idx;
                end else if (P >= i_cmd_pos) begin
                    n_tag   = i_right_ent.tag;
                    n_valid = i_right_ent.valid;
                    n_refs  = i_right_ent.refs;
                    n_idx   = i_right_idx;
                end
            end
            OP_UPDATE: begin
                if (P == i_cmd_pos) begin
                    n_refs = i_cmd.ent.refs;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_tag <= n_tag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_refs  <= '0;
            r_idx   <= P;
        end else begin
            r_valid <= n_valid;
            r_refs  <= n_refs;
            r_idx   <= n_idx;
        end
    end

    // referenced entries always sit ahead of unreferenced ones, so the victim
    // is the first unreferenced position
    assign zero_here = (r_refs == '0);
    assign zero_left = (i_left_ent.refs == '0);
    assign o_vict    = zero_here && (FIRST || !zero_left);

    assign o_match = (i_key_cmd == CMD_READ) ? (r_valid && (r_tag == i_key_tag))
                                             : (i_key_ok && (r_idx == i_key_idx));

    assign o_ent.tag   = r_tag;
    assign o_ent.valid = r_valid;
    assign o_ent.refs  = r_refs;
    assign o_idx       = r_idx;

endmodule

`default_nettype wire

// ===== sim/tb_lru_block_buffer_cache.sv =====
// Self-checking testbench for lru_block_buffer_cache: queue-fed request driver
// with a built-in directory predictor, response monitor, idle-cycle watchdog.
// Depends on lbc_pkg and the RTL top level only.
module tb_lru_block_buffer_cache;
    timeunit 1ns;
    timeprecision 1ps;

    import lbc_pkg::*;

    localparam int N           = ENTRIES_DEF;
    localparam int QUIET_LIMIT = 2000;
    localparam int RAND_ITEMS  = 1550;
    localparam int MAX_PRINTS  = 20;

    typedef struct {
        t_req req;
        int   from_item;   // >= 0: release the slot granted to that earlier read
        int   gap;         // idle cycles after this beat is taken
    } t_req_beat;

    logic  i_clk;
    logic  i_rst_n     = 1'b0;
    logic  i_req_valid = 1'b0;
    logic  o_req_stall;
    t_req  i_req       = '0;
    logic  o_rsp_valid;
    logic  i_rsp_stall = 1'b0;
    t_rsp  o_rsp;

    lru_block_buffer_cache #(.ENTRIES(N)) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // directory image
    logic [31:0] cache_tag   [N];
    bit          cache_valid [N];
    logic [7:0]  cache_refs  [N];
    int          lru_list    [N];   // entry index per position, 0 = head

    t_req_beat pending[$];
    t_rsp      rsp_expected[$];
    logic [5:0] granted_slot[$];    // slot_out of every accepted beat, in order

    t_req_beat next_beat;
    int gap_left;
    int stall_left;
    int rx_cycle;
    bit recv_calm;
    bit sender_calm;
    int quiet_cycles;
    int mismatches;
    int rsp_seen;
    int n_reads, n_hits, n_fetch, n_wb, n_released, n_nofree, n_full, n_notheld;

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("MISMATCH rsp #%0d %s: got %h want %h", rsp_seen, what, got, want);
    endtask

    function automatic void promote(int pos);
        int e;
        int p;
        e = lru_list[pos];
        for (p = pos; p > 0; p--)
            lru_list[p] = lru_list[p - 1];
        lru_list[0] = e;
    endfunction

    function automatic t_rsp cache_access(t_req rq);
        t_rsp res;
        int   p;
        int   v;
        int   e;
        int   hit_pos;
        res = '0;
        hit_pos = -1;
        if (rq.command == CMD_READ) begin
            n_reads++;
            for (p = 0; p < N; p++) begin
                e = lru_list[p];
                if (hit_pos < 0 && cache_valid[e] && cache_tag[e] == rq.block_number)
                    hit_pos = p;
            end
            if (hit_pos >= 0) begin
                e = lru_list[hit_pos];
                res.slot_out = 6'(e);
                res.hit = 1'b1;
                if (cache_refs[e] >= REFS_MAX) begin
                    res.status = ST_FULL;
                end else begin
                    cache_refs[e]++;
                    promote(hit_pos);
                end
            end else if (cache_refs[lru_list[N - 1]] != 0) begin
                res.status = ST_NO_FREE;
            end else begin
                // head-side end of the unreferenced run that reaches the tail
                v = N - 1;
                while (v > 0 && cache_refs[lru_list[v - 1]] == 0)
                    v--;
                e = lru_list[v];
                if (cache_valid[e]) begin
                    res.write_back = 1'b1;
                    res.old_block = cache_tag[e];
                end
                cache_tag[e] = rq.block_number;
                cache_valid[e] = 1'b1;
                cache_refs[e] = 8'd1;
                promote(v);
                res.slot_out = 6'(e);
                res.fetch = 1'b1;
            end
        end else begin
            res.slot_out = rq.slot;
            if (int'(rq.slot) >= N || cache_refs[rq.slot] == 0) begin
                res.status = ST_NOT_HELD;
            end else begin
                n_released++;
                cache_refs[rq.slot]--;
                if (cache_refs[rq.slot] == 0) begin
                    v = 0;
                    for (p = 0; p < N; p++)
                        if (lru_list[p] == int'(rq.slot))
                            v = p;
                    e = lru_list[v];
                    for (p = v; p < N - 1; p++)
                        lru_list[p] = lru_list[p + 1];
                    lru_list[N - 1] = e;
                end
            end
        end
        if (res.hit && res.status == ST_OK) n_hits++;
        if (res.fetch) n_fetch++;
        if (res.write_back) n_wb++;
        case (res.status)
            ST_NO_FREE:  n_nofree++;
            ST_FULL:     n_full++;
            ST_NOT_HELD: n_notheld++;
            default: ;
        endcase
        granted_slot.push_back(res.slot_out);
        return res;
    endfunction

    function automatic int queue_beat(logic cmd, logic [31:0] blk, logic [5:0] slot,
                                      int from_item);
        t_req_beat b;
        int r;
        b.req.command = cmd;
        b.req.block_number = blk;
        b.req.slot = slot;
        b.from_item = from_item;
        r = $urandom_range(99);
        if (sender_calm || r < 65)
            b.gap = 0;
        else if (r < 92)
            b.gap = $urandom_range(3, 1);
        else
            b.gap = $urandom_range(30, 6);
        pending.push_back(b);
        return pending.size() - 1;
    endfunction

    // request driver: the predictor runs on every accepted beat
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_req_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (i_req_valid && !o_req_stall)
                rsp_expected.push_back(cache_access(i_req));
            if (!i_req_valid || !o_req_stall) begin
                if (gap_left > 0) begin
                    i_req_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (pending.size() > 0) begin
                    next_beat = pending.pop_front();
                    if (next_beat.from_item >= 0)
                        next_beat.req.slot = granted_slot[next_beat.from_item];
                    i_req <= next_beat.req;
                    i_req_valid <= 1'b1;
                    gap_left <= next_beat.gap;
                end else begin
                    i_req_valid <= 1'b0;
                end
            end
        end
    end

    // response monitor and receiver stall pattern
    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            i_rsp_stall <= 1'b0;
            stall_left <= 0;
            rx_cycle <= 0;
            recv_calm <= 1'b0;
        end else begin
            if (o_rsp_valid && !i_rsp_stall) begin
                rsp_seen++;
                if (rsp_expected.size() == 0) begin
                    report_mismatch("beat with nothing expected", o_rsp.old_block, '0);
                end else begin
                    want = rsp_expected.pop_front();
                    if (o_rsp.slot_out !== want.slot_out)
                        report_mismatch("slot_out", 32'(o_rsp.slot_out), 32'(want.slot_out));
                    if (o_rsp.hit !== want.hit)
                        report_mismatch("hit", 32'(o_rsp.hit), 32'(want.hit));
                    if (o_rsp.write_back !== want.write_back)
                        report_mismatch("write_back", 32'(o_rsp.write_back),
                                        32'(want.write_back));
                    if (o_rsp.old_block !== want.old_block)
                        report_mismatch("old_block", o_rsp.old_block, want.old_block);
                    if (o_rsp.fetch !== want.fetch)
                        report_mismatch("fetch", 32'(o_rsp.fetch), 32'(want.fetch));
                    if (o_rsp.status !== want.status)
                        report_mismatch("status", 32'(o_rsp.status), 32'(want.status));
                end
            end
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle % 300 == 0)
                recv_calm <= ($urandom_range(3) == 0);
            if (stall_left > 0) begin
                i_rsp_stall <= 1'b1;
                stall_left <= stall_left - 1;
            end else begin
                i_rsp_stall <= 1'b0;
                if (!recv_calm && $urandom_range(99) < 30)
                    stall_left <= ($urandom_range(9) == 0) ? $urandom_range(40, 8)
                                                           : $urandom_range(3, 1);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_req_valid && !o_req_stall) || (o_rsp_valid && !i_rsp_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no beat on either channel for %0d cycles", quiet_cycles);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int open_reads[$];
        int fill_reads[$];
        int i, k, r, idx, bias, first;
        bit sat_done;
        logic [31:0] blk;

        for (i = 0; i < N; i++) begin
            cache_tag[i] = '0;
            cache_valid[i] = 1'b0;
            cache_refs[i] = '0;
            lru_list[i] = i;
        end
        sat_done = 1'b0;
        sender_calm = 1'b0;

        // directed: misses, hits, extreme block numbers, release down to zero,
        // release of an unheld slot, hits on unreferenced entries at and next to the tail
        void'(queue_beat(CMD_READ,    32'h0000_0000, 6'h3F, -1));   // 0
        void'(queue_beat(CMD_READ,    32'hFFFF_FFFF, 6'h00, -1));   // 1
        void'(queue_beat(CMD_READ,    32'h0000_0000, 6'h15, -1));   // 2 hit
        void'(queue_beat(CMD_READ,    32'hFFFF_FFFE, 6'h2A, -1));   // 3
        void'(queue_beat(CMD_READ,    32'h8000_0000, 6'h00, -1));   // 4
        void'(queue_beat(CMD_RELEASE, 32'hFFFF_FFFF, 6'h00, 0));
        void'(queue_beat(CMD_RELEASE, 32'h0000_0000, 6'h00, 0));    // count to zero
        void'(queue_beat(CMD_RELEASE, 32'h0000_0000, 6'h00, 0));    // not held
        void'(queue_beat(CMD_RELEASE, 32'h0000_0000, 6'h3F, -1));   // never used
        void'(queue_beat(CMD_RELEASE, 32'h0000_0000, 6'h00, 1));
        void'(queue_beat(CMD_READ,    32'h0000_0000, 6'h00, -1));   // 10 hit next to tail
        void'(queue_beat(CMD_READ,    32'h0000_0001, 6'h00, -1));   // 11
        void'(queue_beat(CMD_READ,    32'h7FFF_FFFF, 6'h3F, -1));   // 12
        void'(queue_beat(CMD_READ,    32'hFFFF_FFFF, 6'h00, -1));   // 13 tail hit
        void'(queue_beat(CMD_RELEASE, 32'h0000_0000, 6'h00, 10));
        void'(queue_beat(CMD_RELEASE, 32'h0000_0000, 6'h00, 3));
        void'(queue_beat(CMD_RELEASE, 32'h0000_0000, 6'h00, 4));
        void'(queue_beat(CMD_RELEASE, 32'h0000_0000, 6'h00, 11));
        void'(queue_beat(CMD_RELEASE, 32'h0000_0000, 6'h00, 12));
        void'(queue_beat(CMD_RELEASE, 32'h0000_0000, 6'h00, 13));

        // random part: mixed traffic, fills to no-free, one count saturation
        while (pending.size() < RAND_ITEMS + 20) begin
            sender_calm = ($urandom_range(3) == 0);
            r = $urandom_range(9);
            if (!sat_done && pending.size() > 600) begin
                sat_done = 1'b1;
                blk = $urandom;
                first = queue_beat(CMD_READ, blk, 6'($urandom), -1);
                for (k = 0; k < 256; k++)
                    void'(queue_beat(CMD_READ, blk, 6'($urandom), -1));
                for (k = 0; k < 256; k++)
                    void'(queue_beat(CMD_RELEASE, $urandom, 6'h00, first));
            end else if (r == 0 || pending.size() < 60) begin
                blk = $urandom;
                fill_reads.delete();
                for (k = 0; k < N + 2; k++)
                    fill_reads.push_back(queue_beat(CMD_READ, blk + k, 6'($urandom), -1));
                void'(queue_beat(CMD_READ, blk, 6'($urandom), -1));
                fill_reads.push_back(pending.size() - 1);
                fill_reads.shuffle();
                foreach (fill_reads[k])
                    void'(queue_beat(CMD_RELEASE, $urandom, 6'h00, fill_reads[k]));
            end else begin
                bias = $urandom_range(75, 30);
                for (k = 0; k < 40; k++) begin
                    r = $urandom_range(99);
                    if (r < bias) begin
                        r = $urandom_range(99);
                        if (r < 70)
                            blk = $urandom_range(79);
                        else if (r < 85)
                            blk = $urandom;
                        else begin
                            case ($urandom_range(3))
                                0: blk = 32'h0000_0000;
                                1: blk = 32'hFFFF_FFFF;
                                2: blk = 32'hFFFF_FFFE;
                                default: blk = 32'h1 << $urandom_range(31);
                            endcase
                        end
                        idx = queue_beat(CMD_READ, blk, 6'($urandom), -1);
                        open_reads.push_back(idx);
                    end else if (r < bias + (100 - bias) * 3 / 4 && open_reads.size() > 0) begin
                        idx = $urandom_range(open_reads.size() - 1);
                        void'(queue_beat(CMD_RELEASE, $urandom, 6'h00, open_reads[idx]));
                        open_reads.delete(idx);
                    end else begin
                        void'(queue_beat(CMD_RELEASE, $urandom, 6'($urandom_range(63)), -1));
                    end
                end
            end
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending.size() != 0 || i_req_valid || rsp_expected.size() != 0)
            @(negedge i_clk);
        repeat (8) @(posedge i_clk);

        if (rsp_expected.size() != 0)
            report_mismatch("expected beats never seen", rsp_expected.size(), '0);
        $display("Run: %0d beats (%0d reads, %0d hits, %0d fetches, %0d write-backs)",
                 granted_slot.size(), n_reads, n_hits, n_fetch, n_wb);
        $display("     %0d releases, %0d no-free, %0d count-full, %0d unheld; %0d mismatches",
                 n_released, n_nofree, n_full, n_notheld, mismatches);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/lbc_pkg.sv
sv/lbc_cell.sv
sv/lru_block_buffer_cache.sv
sim/tb_lru_block_buffer_cache.sv
